// ===== rtl/core/mapping_table_wx_guard_checker_macros.svh =====
//------------------------------------------------------------------------------
// Assertion macros for the mapping table W^X guard checker
// Shared forms for the concurrent checks; clock clk, reset arst_n.
//------------------------------------------------------------------------------
`ifndef MAPPING_TABLE_WX_GUARD_CHECKER_MACROS_SVH
`define MAPPING_TABLE_WX_GUARD_CHECKER_MACROS_SVH

// same-cycle implication
`define MTWX_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define MTWX_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/core/mtwx_pkg.sv =====
//------------------------------------------------------------------------------
// mtwx_pkg
// Opcodes, status codes, table entry and compare types.
//------------------------------------------------------------------------------
package mtwx_pkg;

	localparam logic [2:0] OP_MAP     = 3'd0;
	localparam logic [2:0] OP_MAP_STK = 3'd1;
	localparam logic [2:0] OP_UNMAP   = 3'd2;
	localparam logic [2:0] OP_BIND    = 3'd3;
	localparam logic [2:0] OP_RELEASE = 3'd4;
	localparam logic [2:0] OP_PREP    = 3'd5;
	localparam logic [2:0] OP_QUERY   = 3'd6;

	localparam logic [3:0] STS_OK         = 4'd0;
	localparam logic [3:0] STS_UNBOUND    = 4'd1;
	localparam logic [3:0] STS_BOUND      = 4'd2;
	localparam logic [3:0] STS_BAD_RANGE  = 4'd3;
	localparam logic [3:0] STS_ALIGN      = 4'd4;
	localparam logic [3:0] STS_OVERLAP    = 4'd5;
	localparam logic [3:0] STS_WX_ALIAS   = 4'd6;
	localparam logic [3:0] STS_FULL       = 4'd7;
	localparam logic [3:0] STS_NO_GUARD   = 4'd8;
	localparam logic [3:0] STS_NOT_MAPPED = 4'd9;
	localparam logic [3:0] STS_NOT_STACK  = 4'd10;
	localparam logic [3:0] STS_INCONS     = 4'd11;

	localparam logic [1:0] RIGHTS_RW = 2'd1;
	localparam logic [1:0] RIGHTS_RX = 2'd2;

	localparam int PAGE_SHIFT = 12;

	typedef struct packed {
		logic [2:0]  owner;
		logic [51:0] vpage;
		logic [51:0] ppage;
		logic [52:0] count;
		logic [3:0]  rks;    // [1:0] rights, [2] kind, [3] kernel stack
	} entry_t;

	typedef struct packed {
		logic [2:0]  sp;
		logic [51:0] vp;
		logic [51:0] pp;
		logic [51:0] np;
		logic [1:0]  rights;
		logic [63:0] va;
		logic [63:0] len;
		logic [63:0] stk;
	} req_t;

	typedef struct packed {
		logic owner_hit;
		logic vovl;
		logic pwx;
		logic guard;
		logic exact;
		logic stkend;
	} flags_t;

	function automatic logic wx_conflict(input logic [1:0] old_r, input logic [1:0] new_r);
		wx_conflict = (old_r == RIGHTS_RW && new_r == RIGHTS_RX) ||
			(old_r == RIGHTS_RX && new_r == RIGHTS_RW);
	endfunction

endpackage

// ===== rtl/core/mapping_table_wx_guard_checker.sv =====
//------------------------------------------------------------------------------
// mapping_table_wx_guard_checker
// Shared mapping table for several address spaces with W^X and guard checks.
//------------------------------------------------------------------------------
// Usage:
//  - Input channel (in_valid / in_stall): one item is one opcode with its
//    operands. in_stall is high while an item is being worked on.
//  - Output channel (out_valid / out_stall): exactly one result item per
//    input item, in order. The result sits in an output register, so a new
//    input item is taken while the previous result still waits.
//  - Sequence: operations that touch the table pass a check step, a scan
//    through the registered RAM read port at one entry per cycle, and a
//    finish step. Bind, and items that fail an early check, skip the scan.
//  - No new item is taken until the current one has left the finish step;
//    the single-entry compare unit sweeps the whole table for each item.
//  - Reset clears valid bits, binding, counts and the sequencer at once; no
//    clearing pass is needed. The entry RAM is not reset.
//  - While the receiver stalls, the finish step waits, leaving the table
//    untouched until the previous result has been taken.
//------------------------------------------------------------------------------
`include "mapping_table_wx_guard_checker_macros.svh"

module mapping_table_wx_guard_checker #(
	parameter int NUM_SPACES     = 8,
	parameter int SPACE_ENTRIES  = 16,
	parameter int LEDGER_ENTRIES = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [2:0]  opcode,
	input  logic [2:0]  space_id,
	input  logic [63:0] virtual_address,
	input  logic [63:0] physical_address,
	input  logic [63:0] range_length,
	input  logic [1:0]  access_rights,
	input  logic        memory_kind,
	input  logic [63:0] entry_address,
	input  logic [63:0] stack_address,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [3:0]  status,
	output logic        range_present,
	output logic [4:0]  space_count,
	output logic [6:0]  total_count,
	output logic        context_ready,
	output logic [63:0] context_entry,
	output logic [63:0] context_stack
);

	localparam int IW   = (LEDGER_ENTRIES > 1) ? $clog2(LEDGER_ENTRIES) : 1;
	localparam int CW   = $clog2(LEDGER_ENTRIES + 1);
	localparam int SPW  = (NUM_SPACES > 1) ? $clog2(NUM_SPACES) : 1;
	localparam int SCW  = $clog2(SPACE_ENTRIES + 1);

	typedef enum logic [3:0] {
		S_IDLE   = 4'b0001,
		S_CHECK  = 4'b0010,
		S_SCAN   = 4'b0100,
		S_FINISH = 4'b1000
	} state_t;

	state_t state_q;

	// request held for the whole operation
	logic [2:0]  op_q, sp_q;
	logic [63:0] va_q, pa_q, len_q, ent_q, stk_q;
	logic [1:0]  rights_q;
	logic        kind_q;

	// table state
	logic [LEDGER_ENTRIES-1:0] valid_q;
	logic [NUM_SPACES-1:0]     bound_q;
	logic [SCW-1:0]            cnt_q [NUM_SPACES];
	logic [CW-1:0]             total_q;

	// check results
	logic [3:0] pre_sts_q, map_pre_q;
	logic       skip_q;

	// scan control and accumulated flags
	logic [CW-1:0] scan_q;
	logic          vld_s1;
	logic [IW-1:0] idx_s1;
	logic          ovl_q, wx_q, guard_q, stkend_q;
	logic          free_q, exact_q;
	logic [IW-1:0] free_idx_q, exact_idx_q;

	// output register
	logic        out_valid_q;
	logic [3:0]  status_q;
	logic        present_q, ready_q;
	logic [4:0]  scount_q;
	logic [6:0]  tcount_q;
	logic [63:0] cent_q, cstk_q;

	logic [SPW-1:0] sp_idx;
	logic           sp_ok, is_bound;
	logic           accept, fin_go, issue;
	logic [IW-1:0]  raddr;

	mtwx_pkg::entry_t rd_entry, wr_entry;
	mtwx_pkg::req_t   req;
	mtwx_pkg::flags_t flags;

	assign sp_idx   = SPW'(sp_q);
	assign sp_ok    = (32'(sp_q) < NUM_SPACES);
	assign is_bound = sp_ok && bound_q[sp_idx];
	assign accept   = in_valid && !in_stall;
	assign in_stall = (state_q != S_IDLE);
	assign fin_go   = (state_q == S_FINISH) && !(out_valid_q && out_stall);
	assign issue    = (state_q == S_SCAN) && (32'(scan_q) < LEDGER_ENTRIES);
	assign raddr    = scan_q[IW-1:0];

	always_comb begin
		req.sp     = sp_q;
		req.vp     = va_q[63:12];
		req.pp     = pa_q[63:12];
		req.np     = len_q[63:12];
		req.rights = (op_q == mtwx_pkg::OP_MAP_STK) ? mtwx_pkg::RIGHTS_RW : rights_q;
		req.va     = va_q;
		req.len    = len_q;
		req.stk    = stk_q;
	end

	//--------------------------------------------------------------------------
	// Early checks, done in S_CHECK
	//--------------------------------------------------------------------------
	logic [3:0] chk_sts, chk_map;
	logic       chk_skip;
	logic       len_ok, va_al, pa_al, wrap;
	logic [64:0] va_end, pa_end;

	always_comb begin
		va_end = {1'b0, va_q} + {1'b0, len_q};
		pa_end = {1'b0, pa_q} + {1'b0, len_q};
		len_ok = (len_q != 64'd0) && (len_q[11:0] == 12'h000);
		va_al  = (va_q[11:0] == 12'h000);
		pa_al  = (pa_q[11:0] == 12'h000);
		wrap   = va_end[64] || pa_end[64];

		// map-level checks after the space and base have passed
		if (!len_ok) chk_map = mtwx_pkg::STS_BAD_RANGE;
		else if (!(va_al && pa_al)) chk_map = mtwx_pkg::STS_ALIGN;
		else if (wrap) chk_map = mtwx_pkg::STS_BAD_RANGE;
		else chk_map = mtwx_pkg::STS_OK;

		chk_sts  = mtwx_pkg::STS_OK;
		chk_skip = 1'b0;
		case (op_q)
			mtwx_pkg::OP_MAP: begin
				if (!is_bound) chk_sts = mtwx_pkg::STS_UNBOUND;
				else chk_sts = chk_map;
				chk_skip = (chk_sts != mtwx_pkg::STS_OK);
			end
			mtwx_pkg::OP_MAP_STK: begin
				if (!is_bound) chk_sts = mtwx_pkg::STS_UNBOUND;
				else if (!va_al) chk_sts = mtwx_pkg::STS_ALIGN;
				else if (va_q[63:12] == 52'd0) chk_sts = mtwx_pkg::STS_NO_GUARD;
				chk_skip = (chk_sts != mtwx_pkg::STS_OK);
			end
			mtwx_pkg::OP_UNMAP: begin
				if (!is_bound) chk_sts = mtwx_pkg::STS_UNBOUND;
				else if (len_q == 64'd0 || !va_al) chk_sts = mtwx_pkg::STS_BAD_RANGE;
				chk_skip = (chk_sts != mtwx_pkg::STS_OK);
			end
			mtwx_pkg::OP_BIND: begin
				if (!sp_ok) chk_sts = mtwx_pkg::STS_UNBOUND;
				else if (bound_q[sp_idx]) chk_sts = mtwx_pkg::STS_BOUND;
				else if (cnt_q[sp_idx] != '0) chk_sts = mtwx_pkg::STS_INCONS;
				chk_skip = 1'b1;
			end
			mtwx_pkg::OP_RELEASE: begin
				if (!is_bound) chk_sts = mtwx_pkg::STS_UNBOUND;
				chk_skip = (chk_sts != mtwx_pkg::STS_OK);
			end
			mtwx_pkg::OP_PREP: begin
				if (!is_bound) chk_sts = mtwx_pkg::STS_UNBOUND;
				else if (ent_q == 64'd0 || stk_q == 64'd0) chk_sts = mtwx_pkg::STS_BAD_RANGE;
				else if (stk_q[11:0] != 12'h000) chk_sts = mtwx_pkg::STS_ALIGN;
				chk_skip = (chk_sts != mtwx_pkg::STS_OK);
			end
			mtwx_pkg::OP_QUERY: begin
				chk_skip = !sp_ok;
			end
			default: begin
				chk_skip = 1'b1;
			end
		endcase
	end

	//--------------------------------------------------------------------------
	// Entry store and shared compare unit
	//--------------------------------------------------------------------------
	logic ram_we;

	mtwx_entry_ram #(
		.DEPTH (LEDGER_ENTRIES),
		.AW    (IW)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (free_idx_q),
		.wdata (wr_entry),
		.raddr (raddr),
		.rdata (rd_entry)
	);

	mtwx_cmp_unit u_cmp (
		.entry (rd_entry),
		.req   (req),
		.flags (flags)
	);

	logic own_s1, valid_s1;
	assign valid_s1 = vld_s1 && valid_q[idx_s1];
	assign own_s1   = valid_s1 && flags.owner_hit;

	//--------------------------------------------------------------------------
	// Final decision, done in S_FINISH
	//--------------------------------------------------------------------------
	logic [3:0]     fin_sts;
	logic           fin_present, fin_ready;
	logic           do_commit, do_unmap, do_release, do_bind, full;
	logic [SCW-1:0] sc_cur, sc_next;
	logic [CW-1:0]  tot_next;

	always_comb begin
		sc_cur      = cnt_q[sp_idx];
		full        = (32'(sc_cur) >= SPACE_ENTRIES) || !free_q;
		fin_sts     = mtwx_pkg::STS_OK;
		fin_present = 1'b0;
		fin_ready   = 1'b0;
		do_commit   = 1'b0;
		do_unmap    = 1'b0;
		do_release  = 1'b0;
		do_bind     = 1'b0;
		if (skip_q) begin
			fin_sts = pre_sts_q;
			do_bind = (op_q == mtwx_pkg::OP_BIND) && (pre_sts_q == mtwx_pkg::STS_OK);
		end else begin
			case (op_q)
				mtwx_pkg::OP_MAP, mtwx_pkg::OP_MAP_STK: begin
					if (op_q == mtwx_pkg::OP_MAP_STK && guard_q) fin_sts = mtwx_pkg::STS_NO_GUARD;
					else if (map_pre_q != mtwx_pkg::STS_OK) fin_sts = map_pre_q;
					else if (ovl_q) fin_sts = mtwx_pkg::STS_OVERLAP;
					else if (wx_q) fin_sts = mtwx_pkg::STS_WX_ALIAS;
					else if (full) fin_sts = mtwx_pkg::STS_FULL;
					else do_commit = 1'b1;
				end
				mtwx_pkg::OP_UNMAP: begin
					if (exact_q) do_unmap = 1'b1;
					else fin_sts = mtwx_pkg::STS_NOT_MAPPED;
				end
				mtwx_pkg::OP_RELEASE: begin
					do_release = 1'b1;
				end
				mtwx_pkg::OP_PREP: begin
					if (stkend_q) fin_ready = 1'b1;
					else fin_sts = mtwx_pkg::STS_NOT_STACK;
				end
				mtwx_pkg::OP_QUERY: begin
					fin_present = exact_q;
				end
				default: begin
					fin_sts = mtwx_pkg::STS_OK;
				end
			endcase
		end

		if (do_commit) sc_next = sc_cur + SCW'(1);
		else if (do_unmap) sc_next = sc_cur - SCW'(1);
		else if (do_release) sc_next = '0;
		else sc_next = sc_cur;

		tot_next = total_q;
		if (do_commit) tot_next = total_q + CW'(1);
		else if (do_unmap) tot_next = total_q - CW'(1);
		else if (do_release) tot_next = total_q - CW'(sc_cur);
	end

	assign ram_we = fin_go && do_commit;

	always_comb begin
		wr_entry.owner = sp_q;
		wr_entry.vpage = va_q[63:12];
		wr_entry.ppage = pa_q[63:12];
		wr_entry.count = {1'b0, len_q[63:12]};
		if (op_q == mtwx_pkg::OP_MAP_STK) wr_entry.rks = {1'b1, 1'b0, mtwx_pkg::RIGHTS_RW};
		else wr_entry.rks = {1'b0, kind_q, rights_q};
	end

	//--------------------------------------------------------------------------
	// Request capture (payload, no reset)
	//--------------------------------------------------------------------------
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q     <= opcode;
			sp_q     <= space_id;
			va_q     <= virtual_address;
			pa_q     <= physical_address;
			len_q    <= range_length;
			rights_q <= access_rights;
			kind_q   <= memory_kind;
			ent_q    <= entry_address;
			stk_q    <= stack_address;
		end
	end

	//--------------------------------------------------------------------------
	// Sequencer, scan and table state
	//--------------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			valid_q     <= '0;
			bound_q     <= '0;
			total_q     <= '0;
			pre_sts_q   <= mtwx_pkg::STS_OK;
			map_pre_q   <= mtwx_pkg::STS_OK;
			skip_q      <= 1'b0;
			scan_q      <= '0;
			vld_s1      <= 1'b0;
			idx_s1      <= '0;
			ovl_q       <= 1'b0;
			wx_q        <= 1'b0;
			guard_q     <= 1'b0;
			stkend_q    <= 1'b0;
			free_q      <= 1'b0;
			exact_q     <= 1'b0;
			free_idx_q  <= '0;
			exact_idx_q <= '0;
			for (int s = 0; s < NUM_SPACES; s++) begin
				cnt_q[s] <= '0;
			end
		end else begin
			vld_s1 <= issue;
			idx_s1 <= raddr;
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						state_q <= S_CHECK;
					end
				end
				S_CHECK: begin
					pre_sts_q <= chk_sts;
					map_pre_q <= chk_map;
					skip_q    <= chk_skip;
					scan_q    <= '0;
					ovl_q     <= 1'b0;
					wx_q      <= 1'b0;
					guard_q   <= 1'b0;
					stkend_q  <= 1'b0;
					free_q    <= 1'b0;
					exact_q   <= 1'b0;
					state_q   <= chk_skip ? S_FINISH : S_SCAN;
				end
				S_SCAN: begin
					if (issue) begin
						scan_q <= scan_q + CW'(1);
					end
					if (vld_s1) begin
						if (own_s1 && flags.vovl) ovl_q <= 1'b1;
						if (own_s1 && flags.guard) guard_q <= 1'b1;
						if (own_s1 && flags.stkend) stkend_q <= 1'b1;
						if (valid_s1 && flags.pwx) wx_q <= 1'b1;
						if (!valid_q[idx_s1] && !free_q) begin
							free_q     <= 1'b1;
							free_idx_q <= idx_s1;
						end
						if (own_s1 && flags.exact && !exact_q) begin
							exact_q     <= 1'b1;
							exact_idx_q <= idx_s1;
						end
						// release drops every entry of the space as it passes
						if (own_s1 && op_q == mtwx_pkg::OP_RELEASE) begin
							valid_q[idx_s1] <= 1'b0;
						end
					end
					if (vld_s1 && !issue) begin
						state_q <= S_FINISH;
					end
				end
				S_FINISH: begin
					if (fin_go) begin
						if (do_commit) valid_q[free_idx_q] <= 1'b1;
						if (do_unmap) valid_q[exact_idx_q] <= 1'b0;
						if (do_bind) bound_q[sp_idx] <= 1'b1;
						if (do_release) bound_q[sp_idx] <= 1'b0;
						if (do_commit || do_unmap || do_release) cnt_q[sp_idx] <= sc_next;
						total_q <= tot_next;
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	//--------------------------------------------------------------------------
	// Output register
	//--------------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fin_go) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fin_go) begin
			status_q  <= fin_sts;
			present_q <= fin_present;
			ready_q   <= fin_ready;
			scount_q  <= sp_ok ? 5'(sc_next) : 5'd0;
			tcount_q  <= 7'(tot_next);
			cent_q    <= fin_ready ? ent_q : 64'd0;
			cstk_q    <= fin_ready ? stk_q : 64'd0;
		end
	end

	assign out_valid     = out_valid_q;
	assign status        = status_q;
	assign range_present = present_q;
	assign space_count   = scount_q;
	assign total_count   = tcount_q;
	assign context_ready = ready_q;
	assign context_entry = cent_q;
	assign context_stack = cstk_q;

	//--------------------------------------------------------------------------
	// Assertions
	//--------------------------------------------------------------------------
	`MTWX_ASSERT_NOW(a_total_range, 1'b1, 32'(total_q) <= LEDGER_ENTRIES, "total count overflow")
	`MTWX_ASSERT_NEXT(a_accept_check, accept, state_q == S_CHECK, "accepted item not checked")
	`MTWX_ASSERT_NOW(a_result_from_finish, $rose(out_valid_q), $past(state_q) == S_FINISH, "result without finish")
	`MTWX_ASSERT_NOW(a_commit_free, ram_we, !valid_q[free_idx_q], "map writes a live entry")

endmodule

// ===== rtl/core/mtwx_entry_ram.sv =====
//------------------------------------------------------------------------------
// mtwx_entry_ram
// Mapping table entry store: one write port, one registered read port.
//------------------------------------------------------------------------------
module mtwx_entry_ram #(
	parameter int DEPTH = 64,
	parameter int AW    = 6
) (
	input  logic            clk,
	input  logic            we,
	input  logic [AW-1:0]   waddr,
	input  mtwx_pkg::entry_t wdata,
	input  logic [AW-1:0]   raddr,
	output mtwx_pkg::entry_t rdata
);

	mtwx_pkg::entry_t mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

// ===== rtl/core/mtwx_cmp_unit.sv =====
//------------------------------------------------------------------------------
// mtwx_cmp_unit
// Compares one table entry against the request held by the sequencer.
//------------------------------------------------------------------------------
module mtwx_cmp_unit (
	input  mtwx_pkg::entry_t entry,
	input  mtwx_pkg::req_t   req,
	output mtwx_pkg::flags_t flags
);

	logic [53:0] e_vend, e_pend, r_vend, r_pend;

	always_comb begin
		e_vend = 54'(entry.vpage) + 54'(entry.count);
		e_pend = 54'(entry.ppage) + 54'(entry.count);
		r_vend = 54'(req.vp) + 54'(req.np);
		r_pend = 54'(req.pp) + 54'(req.np);

		flags.owner_hit = (entry.owner == req.sp);
		flags.vovl = (54'(entry.vpage) < r_vend) && (54'(req.vp) < e_vend);
		flags.pwx = (54'(entry.ppage) < r_pend) && (54'(req.pp) < e_pend) &&
			mtwx_pkg::wx_conflict(entry.rks[1:0], req.rights);
		// guard page is the one just below the request base
		flags.guard = (entry.vpage < req.vp) && (54'(req.vp) <= e_vend);
		flags.exact = ({entry.vpage, 12'h000} == req.va) &&
			({entry.count[51:0], 12'h000} == req.len);
		flags.stkend = entry.rks[3] && (e_vend == 54'(req.stk[63:12]));
	end

endmodule
